/* rtl/pbmt_pkg.sv */
`timescale 1ns / 1ps

package pbmt_pkg;

    // Table geometry
    localparam int SECONDARY_BITS = 8;
    localparam int PRIMARY_BITS   = 2;
    localparam int INDEX_BITS     = PRIMARY_BITS + SECONDARY_BITS;
    localparam int TABLE_DEPTH    = 1 << INDEX_BITS;
    localparam int SLOT_SHIFT     = 3;
    localparam int ADDR_W         = 13;
    localparam int CNT_W          = ADDR_W - SLOT_SHIFT;
    localparam int WORD_W         = 64;
    // One stored entry: valid flag over lock, key, bound, base
    localparam int ENTRY_W        = 4 * WORD_W + 1;

    // Opcodes
    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_COPY  = 2'd2;

    typedef logic [INDEX_BITS-1:0] t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [ENTRY_W-1:0]    t_entry;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] source_address;
        logic [ADDR_W-1:0] copy_bytes;
        logic [WORD_W-1:0] in_base;
        logic [WORD_W-1:0] in_bound;
        logic [WORD_W-1:0] in_key;
        logic [WORD_W-1:0] in_lock;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] out_base;
        logic [WORD_W-1:0] out_bound;
        logic [WORD_W-1:0] out_key;
        logic [WORD_W-1:0] out_lock;
        logic              copy_skipped;
    } t_rsp;

    // Sequencer controls toward the table datapath
    typedef struct packed {
        logic clearing;
        t_idx clear_idx;
        logic idle;
        logic copy_rd;
        t_idx copy_src;
        logic copy_wr;
        t_idx copy_dst;
        logic drain;
    } t_seq_ctl;

    // Slot index of an address, wrapped to the table size
    function automatic t_idx slot_of(input logic [ADDR_W-1:0] a);
        return t_idx'(a >> SLOT_SHIFT);
    endfunction

endpackage

/* rtl/pointer_bounds_metadata_table_core.sv */
`timescale 1ns / 1ps

// Pointer bounds metadata table: one 257-bit entry (valid flag, base, bound, key,
// lock) per 8-byte pointer slot, 1024 slots, held in one single-port-write RAM.
// Requests: i_req is taken at a clock edge where start is high and busy low.
//   store  - writes the entry for address, marks it valid.
//   load   - returns the entry for address, zeros if never written.
//   copy   - moves copy_bytes/8 entries from source_address to address in
//            ascending order, skipping unwritten source slots; a source not
//            8-byte aligned is ignored and flagged with copy_skipped.
// Each request yields exactly one response on o_rsp, marked by o_strobe for
// one cycle; the receiver cannot stall it.
// Store, load, misaligned or empty copy respond in the cycle after the
// request and the next request can follow at once (one per cycle).
// A copy of N entries streams one entry per cycle through the RAM read port
// and holds busy while it runs; its response comes in the last busy cycle.
// Reset (synchronous, active low) starts a clearing pass that zeroes all 1024
// entries, one per cycle; busy stays high until the pass is done.

module pointer_bounds_metadata_table_core
    import pbmt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_rsp o_rsp
);

    t_seq_ctl ctl;
    logic     accept;
    logic     copy_multi;

    logic     ram_we, ram_re;
    t_idx     ram_waddr, ram_raddr;
    t_entry   ram_wdata, ram_rdata;

    logic     r_fwd_hit;
    t_entry   r_fwd_data;
    t_entry   eff_entry;
    logic     eff_valid;

    logic     r_rsp_pend, r_rsp_load, r_rsp_skip;

    assign accept     = start && !busy;
    assign copy_multi = (i_req.opcode == OP_COPY)
                        && (i_req.source_address[SLOT_SHIFT-1:0] == '0)
                        && (i_req.copy_bytes[ADDR_W-1:SLOT_SHIFT] != '0);

    pbmt_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .o_ctl    (ctl),
        .o_busy   (busy)
    );

    // RAM port selection: clearing pass, direct requests, copy stream
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ctl.copy_dst;
        ram_wdata = eff_entry;
        ram_re    = 1'b0;
        ram_raddr = ctl.copy_src;
        if (ctl.clearing) begin
            ram_we    = 1'b1;
            ram_waddr = ctl.clear_idx;
            ram_wdata = '0;
        end else if (ctl.idle) begin
            ram_we    = accept && (i_req.opcode == OP_STORE);
            ram_waddr = slot_of(i_req.address);
            ram_wdata = {1'b1, i_req.in_lock, i_req.in_key, i_req.in_bound, i_req.in_base};
            ram_re    = accept && (i_req.opcode == OP_LOAD);
            ram_raddr = slot_of(i_req.address);
        end else begin
            ram_we = ctl.copy_wr && eff_valid;
            ram_re = ctl.copy_rd;
        end
    end

    pbmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Forward a same-cycle write to the entry being read (overlapping copy)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= ram_we && ram_re && (ram_waddr == ram_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= ram_wdata;
    end

    assign eff_entry = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign eff_valid = eff_entry[ENTRY_W-1];

    // Response tracking for requests answered directly, not through the copy sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_pend <= 1'b0;
            r_rsp_load <= 1'b0;
            r_rsp_skip <= 1'b0;
        end else begin
            r_rsp_pend <= accept && !copy_multi;
            r_rsp_load <= accept && (i_req.opcode == OP_LOAD);
            r_rsp_skip <= accept && (i_req.opcode == OP_COPY)
                          && (i_req.source_address[SLOT_SHIFT-1:0] != '0);
        end
    end

    // Response
    always_comb begin
        o_rsp = '0;
        if (r_rsp_load && eff_valid) begin
            o_rsp.out_base  = eff_entry[WORD_W-1:0];
            o_rsp.out_bound = eff_entry[2*WORD_W-1:WORD_W];
            o_rsp.out_key   = eff_entry[3*WORD_W-1:2*WORD_W];
            o_rsp.out_lock  = eff_entry[4*WORD_W-1:3*WORD_W];
        end
        o_rsp.copy_skipped = r_rsp_skip;
    end

    assign o_strobe = r_rsp_pend || ctl.drain;

    // Checks
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("no clearing pass after reset");
    a_single_cycle_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !copy_multi) |=> o_strobe)
        else $error("missing response to single-cycle request");
    a_no_stray_write_while_busy_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.copy_rd && ram_we) |-> $past(ctl.copy_rd))
        else $error("copy write issued without a preceding copy read");

endmodule

/* rtl/pbmt_ram.sv */
`timescale 1ns / 1ps

module pbmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pbmt_seq.sv */
`timescale 1ns / 1ps

module pbmt_seq
    import pbmt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_req     i_req,
    output t_seq_ctl o_ctl,
    output logic     o_busy
);

    t_state r_state, n_state;
    t_idx   r_clr_idx, n_clr_idx;
    t_idx   r_src, n_src;
    t_idx   r_dst, n_dst;
    t_idx   r_wdst, n_wdst;
    t_cnt   r_cnt, n_cnt;
    logic   r_wr_pend, n_wr_pend;

    t_cnt   req_count;
    logic   copy_start;

    // A copy that moves at least one entry runs in the sequencer
    assign req_count  = t_cnt'(i_req.copy_bytes >> SLOT_SHIFT);
    assign copy_start = i_accept && (i_req.opcode == OP_COPY)
                        && (i_req.source_address[SLOT_SHIFT-1:0] == '0)
                        && (req_count != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == t_idx'(TABLE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (copy_start) begin
                    n_state = ST_COPY;
                end
            end
            ST_COPY: begin
                if (r_cnt == t_cnt'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Counters and copy pointers
    always_comb begin
        n_clr_idx = r_clr_idx;
        n_src     = r_src;
        n_dst     = r_dst;
        n_cnt     = r_cnt;
        n_wdst    = r_wdst;
        n_wr_pend = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                n_clr_idx = r_clr_idx + t_idx'(1);
            end
            ST_IDLE: begin
                n_src = slot_of(i_req.source_address);
                n_dst = slot_of(i_req.address);
                n_cnt = req_count;
            end
            ST_COPY: begin
                n_src     = r_src + t_idx'(1);
                n_dst     = r_dst + t_idx'(1);
                n_cnt     = r_cnt - t_cnt'(1);
                n_wdst    = r_dst;
                n_wr_pend = 1'b1;
            end
            default: begin
                n_wr_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_wr_pend <= n_wr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_cnt  <= n_cnt;
        r_wdst <= n_wdst;
    end

    // Outputs
    always_comb begin
        o_ctl           = '0;
        o_ctl.clear_idx = r_clr_idx;
        o_ctl.copy_src  = r_src;
        o_ctl.copy_dst  = r_wdst;
        o_ctl.copy_wr   = r_wr_pend;
        case (r_state)
            ST_CLEAR: begin
                o_ctl.clearing = 1'b1;
            end
            ST_IDLE: begin
                o_ctl.idle = 1'b1;
            end
            ST_COPY: begin
                o_ctl.copy_rd = 1'b1;
            end
            ST_DRAIN: begin
                o_ctl.drain = 1'b1;
            end
            default: begin
                o_ctl.idle = 1'b0;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    // Checks
    a_wr_pend_only_copying: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> (r_state == ST_COPY || r_state == ST_DRAIN))
        else $error("copy write pending outside a copy");
    a_drain_after_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> $past(r_state) == ST_COPY)
        else $error("drain not preceded by copy");
    a_copy_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY) |-> r_cnt != '0)
        else $error("copy running with zero remaining count");

endmodule

/* sim/tb_pointer_bounds_metadata_table_core.sv */
`timescale 1ns / 1ps

module tb_pointer_bounds_metadata_table_core;
    import pbmt_pkg::*;

    // Opcode value the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_REQS  = 2000;
    localparam int CALM_TAIL    = 300;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [WORD_W-1:0] PAT_A = 64'hA5A5_A5A5_A5A5_A5A5;
    localparam logic [WORD_W-1:0] PAT_B = 64'h5A5A_5A5A_5A5A_5A5A;
    localparam logic [WORD_W-1:0] PAT_C = 64'h0123_4567_89AB_CDEF;
    localparam logic [WORD_W-1:0] PAT_D = 64'hFEDC_BA98_7654_3210;
    localparam logic [WORD_W-1:0] ONES  = '1;

    typedef struct packed {
        logic [WORD_W-1:0] base;
        logic [WORD_W-1:0] bound;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] lock;
    } t_meta_words;

    // One directed request; typed_rsp is used instead of the predictor when typed is set
    typedef struct packed {
        t_req req;
        logic typed;
        t_rsp typed_rsp;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_strobe;
    t_rsp o_rsp;

    // Predictor copy of the table
    t_meta_words slot_words [TABLE_DEPTH];
    bit          slot_written [TABLE_DEPTH];

    t_rsp     pending_rsps [$];
    t_dir_row dir_rows [$];
    int       mismatch_count = 0;

    pointer_bounds_metadata_table_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the predicted table and return its response
    function automatic t_rsp table_access(input t_req r);
        t_rsp        rsp;
        t_idx        src_slot;
        t_idx        dst_slot;
        int unsigned n_slots;
        rsp = '0;
        case (r.opcode)
            OP_STORE: begin
                dst_slot = t_idx'(r.address >> SLOT_SHIFT);
                slot_words[dst_slot] = {r.in_base, r.in_bound, r.in_key, r.in_lock};
                slot_written[dst_slot] = 1'b1;
            end
            OP_LOAD: begin
                src_slot = t_idx'(r.address >> SLOT_SHIFT);
                if (slot_written[src_slot]) begin
                    rsp.out_base  = slot_words[src_slot].base;
                    rsp.out_bound = slot_words[src_slot].bound;
                    rsp.out_key   = slot_words[src_slot].key;
                    rsp.out_lock  = slot_words[src_slot].lock;
                end
            end
            OP_COPY: begin
                if (r.source_address[SLOT_SHIFT-1:0] != '0) begin
                    rsp.copy_skipped = 1'b1;
                end else begin
                    n_slots = 32'(r.copy_bytes >> SLOT_SHIFT);
                    // ascending order, so overlapping ranges see earlier moves
                    for (int unsigned k = 0; k < n_slots; k++) begin
                        src_slot = t_idx'((r.source_address >> SLOT_SHIFT) + k);
                        dst_slot = t_idx'((r.address >> SLOT_SHIFT) + k);
                        if (slot_written[src_slot]) begin
                            slot_words[dst_slot]   = slot_words[src_slot];
                            slot_written[dst_slot] = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic t_req make_req(
        input logic [1:0]        op,
        input logic [ADDR_W-1:0] addr,
        input logic [ADDR_W-1:0] src,
        input logic [ADDR_W-1:0] nbytes,
        input logic [WORD_W-1:0] base,
        input logic [WORD_W-1:0] bound,
        input logic [WORD_W-1:0] key,
        input logic [WORD_W-1:0] lock
    );
        t_req r;
        r.opcode         = op;
        r.address        = addr;
        r.source_address = src;
        r.copy_bytes     = nbytes;
        r.in_base        = base;
        r.in_bound       = bound;
        r.in_key         = key;
        r.in_lock        = lock;
        return r;
    endfunction

    function automatic void add_row(input t_req r, input logic typed, input t_rsp rsp);
        t_dir_row row;
        row.req       = r;
        row.typed     = typed;
        row.typed_rsp = rsp;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Half the addresses land in a small window so loads and copies hit stored slots
    function automatic logic [ADDR_W-1:0] rand_addr();
        if ($urandom_range(0, 1) == 0)
            return ADDR_W'($urandom_range(0, 8191));
        return ADDR_W'($urandom_range(0, 511));
    endfunction

    function automatic t_req rand_req();
        t_req        r;
        int unsigned pick;
        r = make_req(2'($urandom), ADDR_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom),
                     rand_word(), rand_word(), rand_word(), rand_word());
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            r.opcode  = OP_STORE;
            r.address = rand_addr();
        end else if (pick < 70) begin
            r.opcode  = OP_LOAD;
            r.address = rand_addr();
        end else if (pick < 95) begin
            r.opcode  = OP_COPY;
            r.address = rand_addr();
            if ($urandom_range(0, 99) < 85)
                r.source_address = ADDR_W'({rand_addr() >> SLOT_SHIFT, 3'b000});
            // mostly short copies; a few span up to 1023 slots
            if ($urandom_range(0, 99) < 92)
                r.copy_bytes = ADDR_W'($urandom_range(0, 255));
        end else begin
            r.opcode = OP_UNUSED;
        end
        return r;
    endfunction

    // Hold the request until the block takes it, then record its expected response
    task automatic issue_request(input t_req r, input logic typed, input t_rsp typed_rsp);
        t_rsp predicted;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = table_access(r);
        pending_rsps.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic idle_gap(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Response checker: the receiver takes every strobe, in order
    always @(posedge i_clk) begin : rsp_check
        t_rsp exp_rsp;
        logic bad;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_rsps.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response: base=%h bound=%h key=%h lock=%h skip=%b",
                             o_rsp.out_base, o_rsp.out_bound, o_rsp.out_key,
                             o_rsp.out_lock, o_rsp.copy_skipped);
            end else begin
                exp_rsp = pending_rsps.pop_front();
                bad = (o_rsp.out_base !== exp_rsp.out_base)
                    || (o_rsp.out_bound !== exp_rsp.out_bound)
                    || (o_rsp.out_key !== exp_rsp.out_key)
                    || (o_rsp.out_lock !== exp_rsp.out_lock)
                    || (o_rsp.copy_skipped !== exp_rsp.copy_skipped);
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch exp: base=%h bound=%h key=%h lock=%h skip=%b",
                                 exp_rsp.out_base, exp_rsp.out_bound, exp_rsp.out_key,
                                 exp_rsp.out_lock, exp_rsp.copy_skipped);
                        $display("         got: base=%h bound=%h key=%h lock=%h skip=%b",
                                 o_rsp.out_base, o_rsp.out_bound, o_rsp.out_key,
                                 o_rsp.out_lock, o_rsp.copy_skipped);
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_rsp zero_rsp;
        t_rsp skip_rsp;
        t_rsp ones_rsp;
        t_req r;
        bit   calm;

        zero_rsp = '0;
        skip_rsp = '0;
        skip_rsp.copy_skipped = 1'b1;
        ones_rsp = {{4*WORD_W{1'b1}}, 1'b0};
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_written[i] = 1'b0;
            slot_words[i]   = '0;
        end

        // fresh table reads as zero, extremes of address
        add_row(make_req(OP_LOAD, 13'd0, 13'd0, 13'd0, '0, '0, '0, '0), 1'b1, zero_rsp);
        add_row(make_req(OP_LOAD, 13'd8191, '1, '1, ONES, ONES, ONES, ONES), 1'b1, zero_rsp);
        add_row(make_req(OP_STORE, 13'd0, '1, '1, ONES, ONES, ONES, ONES), 1'b1, zero_rsp);
        add_row(make_req(OP_LOAD, 13'd7, '0, '0, '0, '0, '0, '0), 1'b1, ones_rsp);
        add_row(make_req(OP_STORE, 13'd8191, '0, '0, PAT_A, PAT_B, PAT_C, PAT_D), 1'b1,
                zero_rsp);
        add_row(make_req(OP_LOAD, 13'd8184, '0, '0, '0, '0, '0, '0), 1'b0, zero_rsp);
        // unused opcode does nothing
        add_row(make_req(OP_UNUSED, '1, '1, '1, ONES, ONES, ONES, ONES), 1'b1, zero_rsp);
        // misaligned copy sources are flagged
        add_row(make_req(OP_COPY, 13'd0, 13'd1, 13'd8191, '0, '0, '0, '0), 1'b1, skip_rsp);
        add_row(make_req(OP_COPY, 13'd8191, 13'd8191, 13'd8, '0, '0, '0, '0), 1'b1,
                skip_rsp);
        // copy shorter than one slot moves nothing
        add_row(make_req(OP_COPY, 13'd512, 13'd0, 13'd7, '0, '0, '0, '0), 1'b1, zero_rsp);
        add_row(make_req(OP_LOAD, 13'd512, '0, '0, '0, '0, '0, '0), 1'b1, zero_rsp);
        // source range wraps past the top slot
        add_row(make_req(OP_COPY, 13'd800, 13'd8184, 13'd16, '0, '0, '0, '0), 1'b0, zero_rsp);
        add_row(make_req(OP_LOAD, 13'd800, '0, '0, '0, '0, '0, '0), 1'b0, zero_rsp);
        add_row(make_req(OP_LOAD, 13'd808, '0, '0, '0, '0, '0, '0), 1'b0, zero_rsp);
        // low bits of the destination are dropped
        add_row(make_req(OP_COPY, 13'd1003, 13'd0, 13'd8, '0, '0, '0, '0), 1'b0, zero_rsp);
        add_row(make_req(OP_LOAD, 13'd1000, '0, '0, '0, '0, '0, '0), 1'b0, zero_rsp);
        // overlapping ranges smear the first entry forward
        add_row(make_req(OP_STORE, 13'd1600, '0, '0, PAT_D, PAT_C, PAT_B, PAT_A), 1'b0,
                zero_rsp);
        add_row(make_req(OP_COPY, 13'd1608, 13'd1600, 13'd32, '0, '0, '0, '0), 1'b0, zero_rsp);
        add_row(make_req(OP_LOAD, 13'd1632, '0, '0, '0, '0, '0, '0), 1'b0, zero_rsp);
        // unwritten source slot leaves the destination alone
        add_row(make_req(OP_STORE, 13'd2400, '0, '0, PAT_C, PAT_A, PAT_D, PAT_B), 1'b0,
                zero_rsp);
        add_row(make_req(OP_COPY, 13'd2400, 13'd2392, 13'd8, '0, '0, '0, '0), 1'b0, zero_rsp);
        add_row(make_req(OP_LOAD, 13'd2400, '0, '0, '0, '0, '0, '0), 1'b0, zero_rsp);
        // longest copy, destination wraps around the table
        add_row(make_req(OP_COPY, 13'd4096, 13'd0, 13'd8191, '0, '0, '0, '0), 1'b0, zero_rsp);
        add_row(make_req(OP_LOAD, 13'd4096, '0, '0, '0, '0, '0, '0), 1'b0, zero_rsp);
        add_row(make_req(OP_LOAD, 13'd4088, '0, '0, '0, '0, '0, '0), 1'b0, zero_rsp);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            issue_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].typed_rsp);

        // random traffic with bursty gaps, calm stretches and a gap-free tail
        for (int n = 0; n < RANDOM_REQS; n++) begin
            calm = (n >= RANDOM_REQS - CALM_TAIL) || ((n / 64) % 3 == 2);
            if (!calm && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 7));
            r = rand_req();
            issue_request(r, 1'b0, zero_rsp);
        end
        start <= 1'b0;

        while (pending_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("pointer_bounds_metadata_table_core test passed");
        end else begin
            $display("pointer_bounds_metadata_table_core test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #100_000_000;
        $display("pointer_bounds_metadata_table_core test failed");
        $finish;
    end

endmodule
